// ===== design/ptcf_pkg.sv =====
`default_nettype none

package ptcf_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int NUM_SLOTS  = 32;

  localparam int ADDR_W  = 64;
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int TAG_W   = ADDR_W - OFF_W;
  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int SLOT_OUT_W = 5;
  localparam int WOFF_W  = 10;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W  = ADDR_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 1 + SLOT_OUT_W + ADDR_W + WOFF_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // A lookup travelling down the row of cells.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic              found;
    logic [SLOT_W-1:0] which;
  } query_t;

  // Allocation broadcast to every cell on a miss.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    logic              valid;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== design/page_tag_cache_fifo.sv =====
// An input transfer starts a lookup that walks the row of slot cells one cell per clock;
// the result is then registered and loaded into the output register behind out_tvalid.
// A new lookup enters only after the result of the last one is staged, so lookups never overlap.
// A result waiting on the output register does not block the next input transfer.
// Reset (synchronous, rst_n low) clears all valid bits, the victim pointer and the
// handshake state; tags are left as they are, since an invalid slot never matches.
`default_nettype none

module page_tag_cache_fifo
  import ptcf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [63:0] byte_address, [64] fill_ok, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] hit, [1] data_ready, [6:2] slot, [70:7] page_base, [80:71] word_offset, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    victim_r, victim_nxt;
  logic [TAG_W-1:0]     tag_r;
  logic [WOFF_W-1:0]    woff_r;
  logic                 fill_r;
  logic                 res_hit_r;
  logic                 res_ready_r;
  logic [SLOT_W-1:0]    res_slot_r;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                 in_xfer;
  logic                 out_free;
  logic [ADDR_W-1:0]    in_addr;
  query_t               chain [NUM_SLOTS+1];
  query_t               exit_q;
  slot_wr_t             wr;

  assign in_addr   = in_tdata[ADDR_W-1:0];
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    chain[0].valid = in_xfer;
    chain[0].tag   = in_addr[ADDR_W-1:OFF_W];
    chain[0].found = 1'b0;
    chain[0].which = '0;
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptcf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (SLOT_W'(i)),
      .q_i   (chain[i]),
      .wr    (wr),
      .q_o   (chain[i+1])
    );
  end

  assign exit_q = chain[NUM_SLOTS];

  // A miss takes the slot under the pointer once the lookup leaves the row.
  always_comb begin
    wr.en    = exit_q.valid && !exit_q.found;
    wr.idx   = victim_r;
    wr.tag   = tag_r;
    wr.valid = fill_r;
  end

  always_comb begin
    victim_nxt = victim_r;
    if (wr.en) begin
      victim_nxt = (victim_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : victim_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (exit_q.valid) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      victim_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      victim_r <= victim_nxt;
      if (state_r == ST_RESULT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag_r  <= in_addr[ADDR_W-1:OFF_W];
      woff_r <= WOFF_W'(in_addr[OFF_W-1:0] >> 2);
      fill_r <= in_tdata[ADDR_W];
    end
    if (exit_q.valid) begin
      res_hit_r   <= exit_q.found;
      res_ready_r <= exit_q.found | fill_r;
      res_slot_r  <= exit_q.found ? exit_q.which : victim_r;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_tdata_r <= OUT_DATA_W'({woff_r, tag_r, OFF_W'(0), SLOT_OUT_W'(res_slot_r),
                                  res_ready_r, res_hit_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_exit_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    exit_q.valid |-> state_r == ST_SEARCH)
    else $error("lookup left the cell row outside of a search");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_SEARCH)
    else $error("input transfer did not start a search");

  a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    victim_r <= SLOT_W'(NUM_SLOTS - 1))
    else $error("victim pointer out of range");

  a_hit_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[0] |-> out_tdata_r[1])
    else $error("hit reported without data ready");

  a_single_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> !wr.en)
    else $error("two allocations in consecutive cycles");

endmodule

`default_nettype wire

// ===== design/ptcf_cell.sv =====
`default_nettype none

module ptcf_cell
  import ptcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] idx,
  input  wire query_t            q_i,
  input  wire slot_wr_t          wr,
  output query_t                 q_o
);

  logic [TAG_W-1:0] tag_r;
  logic             valid_r;
  query_t           q_r;
  query_t           q_nxt;
  logic             match;

  assign match = valid_r && (tag_r == q_i.tag);

  // The first cell that matches claims the lookup; later cells pass it on.
  always_comb begin
    q_nxt       = q_i;
    q_nxt.found = q_i.found | match;
    q_nxt.which = q_i.found ? q_i.which : idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
      if (wr.en && (wr.idx == idx)) begin
        valid_r <= wr.valid;
      end
    end
    q_r.tag   <= q_nxt.tag;
    q_r.found <= q_nxt.found;
    q_r.which <= q_nxt.which;
    if (wr.en && (wr.idx == idx)) begin
      tag_r <= wr.tag;
    end
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

// ===== test/tb_page_tag_cache_fifo.sv =====
`default_nettype none

module tb_page_tag_cache_fifo;
  import ptcf_pkg::*;

  // Result fields from the lowest bit up: hit, data_ready, slot, page_base, word_offset.
  typedef struct packed {
    logic [WOFF_W-1:0]     word_offset;
    logic [ADDR_W-1:0]     page_base;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  data_ready;
    logic                  hit;
  } lookup_res_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              fill;
    bit                typed;
    lookup_res_t       res;
  } dir_row_t;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int POOL_DEPTH   = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the tag directory.
  logic [TAG_W-1:0] tag_mem [NUM_SLOTS];
  bit               valid_mem [NUM_SLOTS];
  int unsigned      victim_ptr;

  lookup_res_t pending_q [$];
  dir_row_t    dir_rows [$];
  logic [TAG_W-1:0] page_pool [POOL_DEPTH];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  page_tag_cache_fifo u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic lookup_res_t lookup_page(input logic [ADDR_W-1:0] addr, input logic fill);
    lookup_res_t      r;
    logic [TAG_W-1:0] tag;
    int               which;
    tag = addr[ADDR_W-1:OFF_W];
    which = -1;
    // Scan from the top so that the lowest matching slot wins.
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (valid_mem[k] && tag_mem[k] == tag) which = k;
    end
    r.hit = (which >= 0);
    if (which < 0) begin
      which = victim_ptr;
      tag_mem[which] = tag;
      valid_mem[which] = fill;
      victim_ptr = (victim_ptr + 1) % NUM_SLOTS;
      r.data_ready = fill;
    end else begin
      r.data_ready = 1'b1;
    end
    r.slot = which[SLOT_OUT_W-1:0];
    r.page_base = {tag, {OFF_W{1'b0}}};
    r.word_offset = WOFF_W'(addr[OFF_W-1:2]);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input logic [ADDR_W-1:0] addr, input logic fill, input bit typed,
                         input logic hit, input logic ready, input logic [SLOT_OUT_W-1:0] slot,
                         input logic [ADDR_W-1:0] base, input logic [WOFF_W-1:0] woff);
    dir_row_t row;
    row.addr = addr;
    row.fill = fill;
    row.typed = typed;
    row.res.hit = hit;
    row.res.data_ready = ready;
    row.res.slot = slot;
    row.res.page_base = base;
    row.res.word_offset = woff;
    dir_rows = {dir_rows, row};
  endtask

  task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic fill, input bit typed,
                             input lookup_res_t typed_res);
    lookup_res_t pred;
    int          gap;
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({fill, addr});
    do @(posedge clk); while (!in_tready);
    // The shadow directory is updated on every accepted transfer, typed rows included.
    pred = lookup_page(addr, fill);
    pending_q = {pending_q, (typed ? typed_res : pred)};
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                span;
    logic [ADDR_W-1:0] addr;
    logic              fill;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      tag_mem[k] = '0;
      valid_mem[k] = 1'b0;
    end
    victim_ptr = 0;

    // Reset leaves the tags as they are, but nothing is valid, so address zero misses.
    add_row(64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 5'd0, 64'h0, 10'h000);
    add_row(64'h0000_0000_0000_0FFF, 1'b0, 1'b1, 1'b1, 1'b1, 5'd0, 64'h0, 10'h3FF);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 5'd1, 64'hFFFF_FFFF_FFFF_F000,
            10'h3FF);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 5'd2, 64'hFFFF_FFFF_FFFF_F000,
            10'h3FF);
    add_row(64'hFFFF_FFFF_FFFF_F003, 1'b0, 1'b1, 1'b1, 1'b1, 5'd2, 64'hFFFF_FFFF_FFFF_F000,
            10'h000);
    add_row(64'h8000_0000_0000_0004, 1'b1, 1'b1, 1'b0, 1'b1, 5'd3, 64'h8000_0000_0000_0000,
            10'h001);
    add_row(64'h0000_0000_0000_1000, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h0000_0000_0000_0FFC, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'hAAAA_AAAA_AAAA_A555, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h5555_5555_5555_5AAA, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h5555_5555_5555_5AAA, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h1234_5678_9ABC_D7F8, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'h0000_0000_0000_1FFF, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(64'hAAAA_AAAA_AAAA_A000, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0);

    for (int k = 0; k < POOL_DEPTH; k++) page_pool[k] = TAG_W'({$urandom, $urandom});
    page_pool[0] = '0;
    page_pool[1] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_lookup(dir_rows[i].addr, dir_rows[i].fill, dir_rows[i].typed,
                                      dir_rows[i].res);

    // Mostly addresses from a small set of pages so hits, refills and pointer wraps all occur;
    // the working set size changes from phase to phase.
    span = POOL_DEPTH;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        span = $urandom_range(4, POOL_DEPTH);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        addr = {page_pool[$urandom_range(0, span - 1)], OFF_W'($urandom)};
      end else begin
        addr = {$urandom, $urandom};
      end
      fill = ($urandom_range(0, 9) != 0);
      send_lookup(addr, fill, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    lookup_res_t got;
    lookup_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = lookup_res_t'(out_tdata[OUT_FIELDS_W-1:0]);
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing pending: %h", got);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit mismatch: expected %0h, actual %0h", want.hit, got.hit);
          err_cnt++;
        end
        if (got.data_ready !== want.data_ready) begin
          $error("data_ready mismatch: expected %0h, actual %0h", want.data_ready,
                 got.data_ready);
          err_cnt++;
        end
        if (got.slot !== want.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
          err_cnt++;
        end
        if (got.page_base !== want.page_base) begin
          $error("page_base mismatch: expected %h, actual %h", want.page_base, got.page_base);
          err_cnt++;
        end
        if (got.word_offset !== want.word_offset) begin
          $error("word_offset mismatch: expected %h, actual %h", want.word_offset,
                 got.word_offset);
          err_cnt++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
